### rtl/core/ocm_pkg.sv
// Shared types and constants for the occupancy cost map block.
package ocm_pkg;

  typedef struct packed {
    logic [6:0]  width;
    logic [6:0]  height;
    logic [9:0]  cell_mm;
    logic [11:0] radius_mm;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] cost;
  } ring_ent_t;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [7:0] COST_UNKNOWN   = 8'd255;
  localparam logic [7:0] COST_LETHAL    = 8'd254;
  localparam logic [7:0] COST_INSCRIBED = 8'd253;

endpackage

### rtl/core/ocm_cfg.sv
// Configuration registers with an APB-style access port.
module ocm_cfg #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ocm_pkg::cfg_t cfg
);
  import ocm_pkg::*;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CELL   = 2'd2;
  localparam logic [1:0] REG_RADIUS = 2'd3;

  logic [6:0]  map_width;
  logic [6:0]  map_height;
  logic [9:0]  cell_size_mm;
  logic [11:0] inflation_radius_mm;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width           <= 7'd64;
      map_height          <= 7'd64;
      cell_size_mm        <= 10'd100;
      inflation_radius_mm <= 12'd1000;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  map_width           <= pwdata[6:0];
        REG_HEIGHT: map_height          <= pwdata[6:0];
        REG_CELL:   cell_size_mm        <= pwdata[9:0];
        REG_RADIUS: inflation_radius_mm <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {25'd0, map_width};
      REG_HEIGHT: prdata = {25'd0, map_height};
      REG_CELL:   prdata = {22'd0, cell_size_mm};
      REG_RADIUS: prdata = {20'd0, inflation_radius_mm};
    endcase
  end

  always_comb begin
    if (map_width == 7'd0) cfg.width = 7'd1;
    else if (32'(map_width) > MAX_WIDTH) cfg.width = 7'(MAX_WIDTH);
    else cfg.width = map_width;
    if (map_height == 7'd0) cfg.height = 7'd1;
    else if (32'(map_height) > MAX_HEIGHT) cfg.height = 7'(MAX_HEIGHT);
    else cfg.height = map_height;
    cfg.cell_mm   = (cell_size_mm == 10'd0) ? 10'd1 : cell_size_mm;
    cfg.radius_mm = (inflation_radius_mm == 12'd0) ? 12'd1 : inflation_radius_mm;
  end

endmodule

### rtl/core/ocm_ring.sv
// Builds the offset-to-cost ring table in a memory and serves reads from it.
module ocm_ring #(
  parameter int MAX_RADIUS_CELLS = 16,
  parameter int TAB = MAX_RADIUS_CELLS + 1,
  parameter int RAW = $clog2(TAB * TAB),
  parameter int RCW = $clog2(MAX_RADIUS_CELLS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ocm_pkg::cfg_t      cfg,
  output logic               done,
  output logic [RCW-1:0]     rc,
  input  logic [RAW-1:0]     rd_addr,
  output ocm_pkg::ring_ent_t rd_data
);
  import ocm_pkg::*;

  localparam int SW = $clog2(2 * MAX_RADIUS_CELLS * MAX_RADIUS_CELLS + 1);
  localparam int TW = SW + 20;
  localparam int CW = (TW + 16 > 42) ? TW + 16 : 42;

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_DIV  = 3'd1;
  localparam logic [2:0] R_SQ   = 3'd2;
  localparam logic [2:0] R_MUL  = 3'd3;
  localparam logic [2:0] R_RHS1 = 3'd4;
  localparam logic [2:0] R_RHS  = 3'd5;
  localparam logic [2:0] R_SRCH = 3'd6;

  logic [2:0]     state;
  logic [RCW-1:0] q;
  logic [12:0]    dacc;
  logic [19:0]    res2;
  logic [23:0]    r2;
  logic [RCW-1:0] ax;
  logic [RCW-1:0] ay;
  logic [SW-1:0]  s;
  logic [TW-1:0]  t;
  logic [CW-1:0]  rhs;
  logic [CW-1:0]  acc;
  logic [CW-1:0]  stepv;
  logic [7:0]     k;
  logic           inr;
  logic           wr_en;
  ring_ent_t      wr_data;
  logic           last;
  ring_ent_t      ring_mem [TAB*TAB];

  assign last = (32'(ax) == MAX_RADIUS_CELLS) && (32'(ay) == MAX_RADIUS_CELLS);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (state == R_RHS && !inr) begin
      wr_en = 1'b1;
    end else if (state == R_SRCH && !(k < COST_INSCRIBED && acc < rhs)) begin
      wr_en   = 1'b1;
      wr_data = '{valid: 1'b1, cost: COST_INSCRIBED - k};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
      rc    <= '0;
    end else begin
      done <= wr_en && last;
      unique case (state)
        R_IDLE: begin
          if (start) begin
            q     <= '0;
            dacc  <= 13'(cfg.cell_mm);
            state <= R_DIV;
          end
        end
        R_DIV: begin
          if (32'(q) < MAX_RADIUS_CELLS && dacc <= 13'(cfg.radius_mm)) begin
            q    <= q + 1'b1;
            dacc <= dacc + 13'(cfg.cell_mm);
          end else begin
            rc    <= q;
            res2  <= 20'(cfg.cell_mm) * 20'(cfg.cell_mm);
            r2    <= 24'(cfg.radius_mm) * 24'(cfg.radius_mm);
            ax    <= '0;
            ay    <= '0;
            state <= R_SQ;
          end
        end
        R_SQ: begin
          s     <= SW'(ax) * SW'(ax) + SW'(ay) * SW'(ay);
          state <= R_MUL;
        end
        R_MUL: begin
          t     <= TW'(s) * TW'(res2);
          state <= R_RHS1;
        end
        R_RHS1: begin
          rhs   <= CW'(t) * CW'(COST_INSCRIBED);
          inr   <= (ax <= rc) && (ay <= rc) && (CW'(t) <= CW'(r2));
          state <= R_RHS;
        end
        R_RHS: begin
          rhs   <= rhs * CW'(COST_INSCRIBED);
          acc   <= '0;
          k     <= '0;
          stepv <= CW'(r2);
          if (inr) state <= R_SRCH;
        end
        R_SRCH: begin
          if (k < COST_INSCRIBED && acc < rhs) begin
            k     <= k + 8'd1;
            acc   <= acc + stepv;
            stepv <= stepv + CW'({r2, 1'b0});
          end
        end
        default: state <= R_IDLE;
      endcase
      if (wr_en) begin
        if (last) begin
          state <= R_IDLE;
        end else begin
          if (32'(ax) == MAX_RADIUS_CELLS) begin
            ax <= '0;
            ay <= ay + 1'b1;
          end else begin
            ax <= ax + 1'b1;
          end
          state <= R_SQ;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[RAW'(ay) * RAW'(TAB) + RAW'(ax)] <= wr_data;
    end
    rd_data <= ring_mem[rd_addr];
  end

endmodule

### rtl/core/ocm_layers.sv
// Static and inflated cost layer memories, one write and one read port each.
module ocm_layers #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          st_we,
  input  logic [AW-1:0] st_waddr,
  input  logic [7:0]    st_wdata,
  input  logic [AW-1:0] st_raddr,
  output logic [7:0]    st_rdata,
  input  logic          inf_we,
  input  logic [AW-1:0] inf_waddr,
  input  logic [7:0]    inf_wdata,
  input  logic [AW-1:0] inf_raddr,
  output logic [7:0]    inf_rdata
);

  logic [7:0] static_layer   [2**AW];
  logic [7:0] inflated_layer [2**AW];

  always_ff @(posedge clk) begin
    if (st_we) begin
      static_layer[st_waddr] <= st_wdata;
    end
    st_rdata <= static_layer[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (inf_we) begin
      inflated_layer[inf_waddr] <= inf_wdata;
    end
    inf_rdata <= inflated_layer[inf_raddr];
  end

endmodule

### rtl/core/ocm_sweep.sv
// Inflation sequencer: walks every cell and scans the window of each free cell through memory reads.
module ocm_sweep #(
  parameter int MAX_RADIUS_CELLS = 16,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  ocm_pkg::cfg_t cfg,
  output logic          busy,
  output logic          done,
  output logic [AW-1:0] st_raddr,
  input  logic [7:0]    st_rdata,
  output logic          inf_we,
  output logic [AW-1:0] inf_waddr,
  output logic [7:0]    inf_wdata
);
  import ocm_pkg::*;

  localparam int TAB = MAX_RADIUS_CELLS + 1;
  localparam int RAW = $clog2(TAB * TAB);
  localparam int RCW = $clog2(MAX_RADIUS_CELLS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RING  = 3'd1;
  localparam logic [2:0] S_CELL  = 3'd2;
  localparam logic [2:0] S_CWAIT = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]         state;
  logic [6:0]         x;
  logic [6:0]         y;
  logic [AW-1:0]      cidx;
  logic signed [RCW:0] dy;
  logic signed [RCW:0] dx;
  logic signed [RCW:0] rcs;
  logic [7:0]         best;
  logic               pv;
  logic               ring_done;
  logic [RCW-1:0]     rc;
  logic [RAW-1:0]     ring_addr;
  ring_ent_t          ring_data;
  logic signed [8:0]  ny;
  logic signed [8:0]  nx;
  logic               nok;
  logic [RCW:0]       ady;
  logic [RCW:0]       adx;
  logic               advance;
  logic               last_cell;

  ocm_ring #(.MAX_RADIUS_CELLS(MAX_RADIUS_CELLS)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .start   (go && state == S_IDLE),
    .cfg     (cfg),
    .done    (ring_done),
    .rc      (rc),
    .rd_addr (ring_addr),
    .rd_data (ring_data)
  );

  assign rcs  = $signed({1'b0, rc});
  assign ny   = $signed({2'b00, y}) + 9'(dy);
  assign nx   = $signed({2'b00, x}) + 9'(dx);
  assign nok  = (ny >= 0) && (ny < $signed({2'b00, cfg.height})) &&
                (nx >= 0) && (nx < $signed({2'b00, cfg.width}));
  assign ady  = (dy < 0) ? -dy : dy;
  assign adx  = (dx < 0) ? -dx : dx;
  assign ring_addr = RAW'(ady) * RAW'(TAB) + RAW'(adx);
  assign last_cell = (x == cfg.width - 7'd1) && (y == cfg.height - 7'd1);

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    if (state == S_SCAN) begin
      st_raddr = AW'(14'(ny[6:0]) * 14'(cfg.width) + 14'(nx[6:0]));
    end else begin
      st_raddr = cidx;
    end
    inf_waddr = cidx;
    inf_we    = 1'b0;
    inf_wdata = best;
    advance   = 1'b0;
    if (state == S_CWAIT && st_rdata != 8'd0) begin
      inf_we    = 1'b1;
      inf_wdata = st_rdata;
      advance   = 1'b1;
    end else if (state == S_WRITE) begin
      inf_we  = 1'b1;
      advance = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
    end else begin
      pv <= (state == S_SCAN) && nok;
      if (pv && st_rdata != 8'd0 && st_rdata != COST_UNKNOWN && ring_data.valid &&
          ring_data.cost > best) begin
        best <= ring_data.cost;
      end
      unique case (state)
        S_IDLE: begin
          if (go) begin
            x     <= '0;
            y     <= '0;
            cidx  <= '0;
            state <= S_RING;
          end
        end
        S_RING: begin
          if (ring_done) state <= S_CELL;
        end
        S_CELL: state <= S_CWAIT;
        S_CWAIT: begin
          if (st_rdata == 8'd0) begin
            dy    <= -rcs;
            dx    <= -rcs;
            best  <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (dx == rcs) begin
            dx <= -rcs;
            if (dy == rcs) state <= S_DRAIN;
            else dy <= dy + 1'b1;
          end else begin
            dx <= dx + 1'b1;
          end
        end
        S_DRAIN: state <= S_WRITE;
        S_WRITE: ;
        S_DONE:  state <= S_IDLE;
      endcase
      if (advance) begin
        cidx <= cidx + 1'b1;
        if (last_cell) begin
          state <= S_DONE;
        end else begin
          state <= S_CELL;
          if (x == cfg.width - 7'd1) begin
            x <= '0;
            y <= y + 7'd1;
          end else begin
            x <= x + 7'd1;
          end
        end
      end
    end
  end

endmodule

### rtl/core/occupancy_costmap_inflation.sv
// Top level of the occupancy cost map with obstacle inflation.
//
//  channel   ports                                        direction
//  config    psel penable pwrite paddr pwdata prdata      APB, 4 registers
//  request   start busy command occ_pct cell_index        in, taken at start && !busy
//  result    strobe static_cost infl_cost done_res        out, one-cycle strobe
//
// A load gives no result; a read answers in the cycle after it is taken.
// Loads and reads are taken every cycle while busy is low; the static layer memory port sets that rate.
// A run divides the radius by the cell size, builds the (MAX_RADIUS_CELLS+1)^2 ring
// table, then walks the map: a cell with a nonzero static cost is copied, a free cell
// scans its (2R+1)^2 window, R the radius in cells. busy stays high until the done
// result. rst is synchronous; layers hold garbage until written.
module occupancy_costmap_inflation #(
  parameter int MAX_WIDTH        = 64,
  parameter int MAX_HEIGHT       = 64,
  parameter int MAX_RADIUS_CELLS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic signed [7:0] occ_pct,
  input  logic [11:0] cell_index,
  output logic        strobe,
  output logic [7:0]  static_cost,
  output logic [7:0]  infl_cost,
  output logic        done_res
);
  import ocm_pkg::*;

  localparam int AW = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

  cfg_t          cfg;
  logic          accept;
  logic          in_map;
  logic [7:0]    load_cost;
  logic          sweep_done;
  logic [AW-1:0] sweep_raddr;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;
  logic [7:0]    inf_rdata;
  logic          inf_we;
  logic [AW-1:0] inf_waddr;
  logic [7:0]    inf_wdata;
  logic          rd_pend;
  logic          rd_in;
  logic          done_pend;

  function automatic logic [7:0] occ_to_cost(input logic signed [7:0] v);
    logic [14:0] p;
    logic [27:0] m;
    p = 15'(v[6:0]) * 15'd254;
    m = 28'(p) * 28'd5243;
    if (v < 0) return COST_UNKNOWN;
    else if (v == 0) return 8'd0;
    else if (v >= 8'sd100) return COST_LETHAL;
    else return m[26:19];
  endfunction

  ocm_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept    = start && !busy;
  assign in_map    = {2'b00, cell_index} < 14'(cfg.width) * 14'(cfg.height);
  assign load_cost = occ_to_cost(occ_pct);
  assign st_raddr  = busy ? sweep_raddr : AW'(cell_index);

  ocm_sweep #(.MAX_RADIUS_CELLS(MAX_RADIUS_CELLS), .AW(AW)) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .go        (accept && command == CMD_RUN),
    .cfg       (cfg),
    .busy      (busy),
    .done      (sweep_done),
    .st_raddr  (sweep_raddr),
    .st_rdata  (st_rdata),
    .inf_we    (inf_we),
    .inf_waddr (inf_waddr),
    .inf_wdata (inf_wdata)
  );

  ocm_layers #(.AW(AW)) u_layers (
    .clk       (clk),
    .st_we     (accept && command == CMD_LOAD && in_map),
    .st_waddr  (AW'(cell_index)),
    .st_wdata  (load_cost),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata),
    .inf_we    (inf_we),
    .inf_waddr (inf_waddr),
    .inf_wdata (inf_wdata),
    .inf_raddr (AW'(cell_index)),
    .inf_rdata (inf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      done_pend <= 1'b0;
    end else begin
      rd_pend   <= accept && command == CMD_READ;
      done_pend <= sweep_done;
    end
    rd_in <= in_map;
  end

  assign strobe      = rd_pend || done_pend;
  assign static_cost = (rd_pend && rd_in) ? st_rdata : 8'd0;
  assign infl_cost   = (rd_pend && rd_in) ? inf_rdata : 8'd0;
  assign done_res    = done_pend;

`ifndef SYNTHESIS
  a_done_strobe: assert property (@(posedge clk) disable iff (rst)
    done_res |-> strobe && !busy) else $error("done result without strobe or while busy");
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && command == CMD_RUN)) else $error("busy without run request");
  a_single: assert property (@(posedge clk) disable iff (rst)
    !(rd_pend && done_pend)) else $error("read and done results collide");
`endif

endmodule
